/* design/acld_pkg.sv */
// Shared types, constants and keyword table for the ASCII line command decoder.
`timescale 1ns / 1ps
`default_nettype none
package acld_pkg;

  localparam int LINE_BUF_SIZE = 128;
  localparam int LEN_W         = $clog2(LINE_BUF_SIZE);
  localparam int KW_COUNT      = 8;
  localparam int KW_MAX        = 13;
  localparam int ARG_W         = 32;
  localparam int MODE_W        = 3;
  localparam int CNT_W         = 32;
  localparam int SUM_W         = ARG_W + 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;

  // highest valid mode; larger SET_MODE arguments are rejected
  localparam logic [MODE_W-1:0] MODE_TOP = 3'd4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 36'sd2147483647;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -36'sd2147483648;

  typedef enum logic [3:0] {
    RSP_STATUS      = 4'd0,
    RSP_MODE_SET    = 4'd1,
    RSP_BAD_MODE    = 4'd2,
    RSP_CALIBRATED  = 4'd3,
    RSP_RATE_SET    = 4'd4,
    RSP_IMU         = 4'd5,
    RSP_TELEMETRY   = 4'd6,
    RSP_LED_ON      = 4'd7,
    RSP_LED_OFF     = 4'd8,
    RSP_BAD_LED     = 4'd9,
    RSP_RESETTING   = 4'd10,
    RSP_UNKNOWN     = 4'd11
  } resp_t;

  typedef enum logic [2:0] {
    PH_PRE   = 3'd0,
    PH_BLANK = 3'd1,
    PH_POS   = 3'd2,
    PH_NEG   = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    LW_START = 3'd0,
    LW_O     = 3'd1,
    LW_ON    = 3'd2,
    LW_OF    = 3'd3,
    LW_OFF   = 3'd4,
    LW_BAD   = 3'd7
  } ledw_t;

  // Summary of a finished line, handed from the scanner to the executor.
  typedef struct packed {
    logic                     done;
    resp_t                    kw_code;
    logic signed [ARG_W-1:0]  arg;
    ledw_t                    led_word;
  } line_t;

  // Keywords, right-aligned in a fixed-width packed string.
  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    {"GET_", "STATUS"}, {"SET_", "MODE:"}, "CALIBRATE", {"SET_", "RATE:"},
    "GET_IMU", {"GET_", "TELEMETRY"}, "SET_LED:", "RESET"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd10, 4'd9, 4'd9, 4'd9, 4'd7, 4'd13, 4'd8, 4'd5
  };
  localparam resp_t KW_CODE [KW_COUNT] = '{
    RSP_STATUS, RSP_MODE_SET, RSP_CALIBRATED, RSP_RATE_SET,
    RSP_IMU, RSP_TELEMETRY, RSP_LED_ON, RSP_RESETTING
  };

  // Character at position pos of keyword k; meaningful for pos < KW_LEN[k].
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
    logic [8*KW_MAX-1:0] txt;
    logic [3:0]          idx;
    txt = KW_TEXT[k];
    idx = KW_LEN[k] - 4'd1 - pos;
    return txt[{idx, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

/* design/acld_scan.sv */
// Per-byte line scanner: length, keyword prefix match, argument parse, LED word.
`timescale 1ns / 1ps
`default_nettype none
module acld_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output acld_pkg::line_t     line
);

  logic [acld_pkg::LEN_W-1:0]           len_r;
  logic [acld_pkg::KW_COUNT-1:0]        alive_r, alive_nxt;
  logic                                 ended_r;
  logic signed [acld_pkg::ARG_W-1:0]    arg_r, arg_nxt;
  acld_pkg::phase_t                     phase_r, phase_nxt;
  acld_pkg::ledw_t                      ledw_r, ledw_nxt;

  logic       is_eol, keep, match, nul_hit, digit, blank;
  logic       add_en, add_neg;
  logic [3:0] dval;
  logic signed [acld_pkg::SUM_W-1:0] ext, prod, sum;
  acld_pkg::resp_t kw_code;

  assign is_eol  = (rx_byte == acld_pkg::CH_CR) || (rx_byte == acld_pkg::CH_LF);
  assign keep    = !is_eol && (len_r < acld_pkg::LEN_W'(acld_pkg::LINE_BUF_SIZE - 1));
  assign match   = keep && !ended_r && (rx_byte != acld_pkg::CH_NUL);
  assign nul_hit = keep && !ended_r && (rx_byte == acld_pkg::CH_NUL);
  assign digit   = (rx_byte >= acld_pkg::CH_0) && (rx_byte <= acld_pkg::CH_9);
  assign blank   = rx_byte inside {acld_pkg::CH_SPACE, [acld_pkg::CH_TAB:acld_pkg::CH_CR]};
  assign dval    = 4'(rx_byte - acld_pkg::CH_0);

  // prefix kill: mismatch at a position inside the keyword, or NUL inside it
  always_comb begin
    alive_nxt = alive_r;
    for (int k = 0; k < acld_pkg::KW_COUNT; k++) begin
      if (len_r < acld_pkg::LEN_W'(acld_pkg::KW_LEN[k])) begin
        if (nul_hit || (rx_byte != acld_pkg::kw_char(3'(k), len_r[3:0]))) begin
          alive_nxt[k] = 1'b0;
        end
      end
    end
  end

  // argument phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      acld_pkg::PH_PRE: begin
        if (rx_byte == acld_pkg::CH_COLON) phase_nxt = acld_pkg::PH_BLANK;
      end
      acld_pkg::PH_BLANK: begin
        if (blank) phase_nxt = acld_pkg::PH_BLANK;
        else if (rx_byte == acld_pkg::CH_PLUS) phase_nxt = acld_pkg::PH_POS;
        else if (rx_byte == acld_pkg::CH_MINUS) phase_nxt = acld_pkg::PH_NEG;
        else if (digit) phase_nxt = acld_pkg::PH_POS;
        else phase_nxt = acld_pkg::PH_DONE;
      end
      acld_pkg::PH_POS, acld_pkg::PH_NEG: begin
        if (!digit) phase_nxt = acld_pkg::PH_DONE;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // digit accumulate control
  always_comb begin
    add_en  = 1'b0;
    add_neg = 1'b0;
    case (phase_r)
      acld_pkg::PH_BLANK: add_en = digit && !blank;
      acld_pkg::PH_POS:   add_en = digit;
      acld_pkg::PH_NEG: begin
        add_en  = digit;
        add_neg = 1'b1;
      end
      default: add_en = 1'b0;
    endcase
  end

  // arg*10 +/- d, saturated to 32-bit signed
  always_comb begin
    ext  = {{(acld_pkg::SUM_W - acld_pkg::ARG_W){arg_r[acld_pkg::ARG_W-1]}}, arg_r};
    prod = (ext <<< 3) + (ext <<< 1);
    sum  = add_neg ? (prod - acld_pkg::SUM_W'(dval)) : (prod + acld_pkg::SUM_W'(dval));
    if (!add_en) arg_nxt = arg_r;
    else if (sum > acld_pkg::SUM_MAX) arg_nxt = acld_pkg::SUM_MAX[acld_pkg::ARG_W-1:0];
    else if (sum < acld_pkg::SUM_MIN) arg_nxt = acld_pkg::SUM_MIN[acld_pkg::ARG_W-1:0];
    else arg_nxt = sum[acld_pkg::ARG_W-1:0];
  end

  // LED word tracker, runs once the colon has been seen
  always_comb begin
    ledw_nxt = ledw_r;
    if (phase_r != acld_pkg::PH_PRE) begin
      case (ledw_r)
        acld_pkg::LW_START: ledw_nxt = (rx_byte == acld_pkg::CH_O) ? acld_pkg::LW_O
                                                                   : acld_pkg::LW_BAD;
        acld_pkg::LW_O: begin
          if (rx_byte == acld_pkg::CH_N) ledw_nxt = acld_pkg::LW_ON;
          else if (rx_byte == acld_pkg::CH_F) ledw_nxt = acld_pkg::LW_OF;
          else ledw_nxt = acld_pkg::LW_BAD;
        end
        acld_pkg::LW_OF: ledw_nxt = (rx_byte == acld_pkg::CH_F) ? acld_pkg::LW_OFF
                                                                : acld_pkg::LW_BAD;
        default: ledw_nxt = acld_pkg::LW_BAD;
      endcase
    end
  end

  // first live keyword whose length fits wins
  always_comb begin
    kw_code = acld_pkg::RSP_UNKNOWN;
    for (int k = acld_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (alive_r[k] && (len_r >= acld_pkg::LEN_W'(acld_pkg::KW_LEN[k]))) begin
        kw_code = acld_pkg::KW_CODE[k];
      end
    end
  end

  assign line.done     = step && is_eol && (len_r != '0);
  assign line.kw_code  = kw_code;
  assign line.arg      = arg_r;
  assign line.led_word = ledw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      alive_r <= '1;
      ended_r <= 1'b0;
      arg_r   <= '0;
      phase_r <= acld_pkg::PH_PRE;
      ledw_r  <= acld_pkg::LW_START;
    end else if (step) begin
      if (is_eol) begin
        len_r   <= '0;
        alive_r <= '1;
        ended_r <= 1'b0;
        arg_r   <= '0;
        phase_r <= acld_pkg::PH_PRE;
        ledw_r  <= acld_pkg::LW_START;
      end else if (keep) begin
        len_r <= len_r + 1'b1;
        if (nul_hit) begin
          ended_r <= 1'b1;
          alive_r <= alive_nxt;
        end else if (match) begin
          alive_r <= alive_nxt;
          arg_r   <= arg_nxt;
          phase_r <= phase_nxt;
          ledw_r  <= ledw_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/acld_exec.sv */
// Command executor: mode, LED and command counter state, final response code.
`timescale 1ns / 1ps
`default_nettype none
module acld_exec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  acld_pkg::line_t                   line,
  output acld_pkg::resp_t                   code,
  output logic [acld_pkg::MODE_W-1:0]       mode,
  output logic signed [acld_pkg::ARG_W-1:0] rate,
  output logic [acld_pkg::CNT_W-1:0]        total,
  output logic                              led
);

  logic [acld_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                        led_r, led_nxt;
  logic [acld_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    code     = line.kw_code;
    mode_nxt = mode_r;
    led_nxt  = led_r;
    rate     = '0;
    cnt_nxt  = cnt_r + 1'b1;
    case (line.kw_code)
      acld_pkg::RSP_MODE_SET: begin
        if (!line.arg[acld_pkg::ARG_W-1] &&
            (line.arg <= acld_pkg::ARG_W'(acld_pkg::MODE_TOP))) begin
          mode_nxt = line.arg[acld_pkg::MODE_W-1:0];
        end else begin
          code = acld_pkg::RSP_BAD_MODE;
        end
      end
      acld_pkg::RSP_RATE_SET: rate = line.arg;
      acld_pkg::RSP_LED_ON: begin
        if (line.led_word == acld_pkg::LW_ON) begin
          led_nxt = 1'b1;
        end else if (line.led_word == acld_pkg::LW_OFF) begin
          led_nxt = 1'b0;
          code    = acld_pkg::RSP_LED_OFF;
        end else begin
          code = acld_pkg::RSP_BAD_LED;
        end
      end
      default: code = line.kw_code;
    endcase
  end

  assign mode  = mode_nxt;
  assign led   = led_nxt;
  assign total = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      led_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (line.done) begin
      mode_r <= mode_nxt;
      led_r  <= led_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/ascii_line_command_decoder_top.sv */
// Top level of the ASCII line command decoder: input register, scanner, executor, result register.
// Pipeline: a byte request is taken into the input register, then decoded from it; a line-ending
//   byte's result goes into the result register and on to the out_ ports (two register stages).
// Throughput: one byte per cycle, sustained; a stalled result holds the decode stage,
//   so once the input register is also full the input stalls until the result is taken.
// Reset (rst_n low, synchronous): mode zero, LED off, command count zero, line empty.
`timescale 1ns / 1ps
`default_nettype none
module ascii_line_command_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_response_code,
  output logic [acld_pkg::MODE_W-1:0]       out_mode_now,
  output logic signed [acld_pkg::ARG_W-1:0] out_rate_echo,
  output logic [acld_pkg::CNT_W-1:0]        out_command_total,
  output logic                              out_led_lit
);

  // input register
  logic       in_vld_r;
  logic [7:0] byte_r;

  // result register
  logic                              out_vld_r;
  logic [3:0]                        code_r;
  logic [acld_pkg::MODE_W-1:0]       mode_r;
  logic signed [acld_pkg::ARG_W-1:0] rate_r;
  logic [acld_pkg::CNT_W-1:0]        total_r;
  logic                              led_r;

  logic advance;   // decode stage may move: result slot empty or being taken
  logic step;      // a byte is decoded this cycle
  logic in_take;   // input request accepted this cycle

  acld_pkg::line_t                   line;
  acld_pkg::resp_t                   code;
  logic [acld_pkg::MODE_W-1:0]       mode;
  logic signed [acld_pkg::ARG_W-1:0] rate;
  logic [acld_pkg::CNT_W-1:0]        total;
  logic                              led;

  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_rx_byte;
    end
  end

  // line scanner: keeps the partial-line state and summarizes a finished line
  acld_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .line    (line)
  );

  // executor: applies the command to mode / LED / counter
  acld_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .line  (line),
    .code  (code),
    .mode  (mode),
    .rate  (rate),
    .total (total),
    .led   (led)
  );

  // only line ends with kept bytes produce a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= line.done;
    end
  end

  always_ff @(posedge clk) begin
    if (line.done) begin
      code_r  <= code;
      mode_r  <= mode;
      rate_r  <= rate;
      total_r <= total;
      led_r   <= led;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_response_code = code_r;
  assign out_mode_now      = mode_r;
  assign out_rate_echo     = rate_r;
  assign out_command_total = total_r;
  assign out_led_lit       = led_r;

endmodule
`default_nettype wire

/* design/acld_checker.sv */
// Port-level checker for the ASCII line command decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module acld_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [7:0]                        in_rx_byte,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [3:0]                        out_response_code,
  input logic [acld_pkg::MODE_W-1:0]       out_mode_now,
  input logic signed [acld_pkg::ARG_W-1:0] out_rate_echo,
  input logic [acld_pkg::CNT_W-1:0]        out_command_total,
  input logic                              out_led_lit
);

  logic                       seen_r;
  logic [acld_pkg::CNT_W-1:0] last_total_r;
  logic                       out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_total_r <= '0;
    end else if (out_take) begin
      seen_r       <= 1'b1;
      last_total_r <= out_command_total;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled byte request changed");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_response_code) &&
      $stable(out_command_total) && $stable(out_rate_echo) && $stable(out_led_lit))
    else $error("stalled response changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_response_code <= 4'(acld_pkg::RSP_UNKNOWN)) &&
      (out_mode_now <= acld_pkg::MODE_TOP))
    else $error("response code or mode out of range");

  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_response_code != 4'(acld_pkg::RSP_RATE_SET)) |-> out_rate_echo == '0)
    else $error("rate echo nonzero on a non-rate command");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_command_total == last_total_r + 1'b1)
    else $error("command count did not advance by one");

endmodule

bind ascii_line_command_decoder_top acld_checker u_acld_checker (.*);
`default_nettype wire
